[src/srat_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the section range address translator.
// No dependencies; every other file depends on this package.
package srat_pkg;

   localparam int MAX_SECTIONS = 16;
   localparam int SEC_AW       = $clog2(MAX_SECTIONS);
   localparam int NUM_W        = $clog2(MAX_SECTIONS + 1);
   localparam int CNT_W        = 5;
   localparam int ADDR_W       = 32;
   localparam int IDX_W        = 4;
   localparam int OP_W         = 2;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_QVA  = 2'd1,
      OP_QFO  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    entry_index;
      logic [ADDR_W-1:0]   virtual_base;
      logic [ADDR_W-1:0]   raw_size;
      logic [ADDR_W-1:0]   virtual_size;
      logic [ADDR_W-1:0]   file_base;
      logic [ADDR_W-1:0]   query_address;
   } item_type;

   // Table entry with range ends precomputed at load time (33 bits, no wrap).
   typedef struct packed {
      logic [ADDR_W-1:0]   virtual_base;
      logic [ADDR_W-1:0]   file_base;
      logic [ADDR_W-1:0]   delta;
      logic [ADDR_W:0]     raw_end;
      logic [ADDR_W:0]     image_end;
      logic [ADDR_W:0]     file_end;
   } entry_type;

   typedef struct packed {
      logic                hit;
      logic [ADDR_W-1:0]   translated;
      logic [IDX_W-1:0]    hit_section;
      logic                in_image;
      logic [IDX_W-1:0]    image_section;
   } result_type;

endpackage

[src/srat_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the section range address translator.
// Depends on srat_pkg for field widths.
interface srat_req_if;
   logic                           valid;
   logic                           ready;
   logic [srat_pkg::OP_W-1:0]      op;
   logic [srat_pkg::IDX_W-1:0]     entry_index;
   logic [srat_pkg::ADDR_W-1:0]    entry_virtual_base;
   logic [srat_pkg::ADDR_W-1:0]    entry_raw_size;
   logic [srat_pkg::ADDR_W-1:0]    entry_virtual_size;
   logic [srat_pkg::ADDR_W-1:0]    entry_file_base;
   logic [srat_pkg::ADDR_W-1:0]    query_address;

   modport source (output valid, op, entry_index, entry_virtual_base, entry_raw_size,
                   entry_virtual_size, entry_file_base, query_address, input ready);
   modport sink   (input valid, op, entry_index, entry_virtual_base, entry_raw_size,
                   entry_virtual_size, entry_file_base, query_address, output ready);
endinterface

interface srat_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [srat_pkg::ADDR_W-1:0]    translated;
   logic [srat_pkg::IDX_W-1:0]     hit_section;
   logic                           in_image;
   logic [srat_pkg::IDX_W-1:0]     image_section;

   modport source (output valid, hit, translated, hit_section, in_image, image_section,
                   input ready);
   modport sink   (input valid, hit, translated, hit_section, in_image, image_section,
                   output ready);
endinterface

[src/srat_front.sv]
`timescale 1ns / 1ps
// Front stage: accepts request beats, decodes the op and drops unused codes.
// Depends on srat_pkg and srat_req_if.
module srat_front (
   input  logic               clock,
   input  logic               reset,
   srat_req_if.sink           req_ch,
   output srat_pkg::item_type push_item,
   output logic               push_valid,
   input  logic               push_ready
);
   import srat_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff;
   logic     accept;
   op_type   dec_op;

   assign req_ch.ready = !hold_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign dec_op = op_type'(req_ch.op);

   // unused op code gives no beat downstream
   always_comb begin
      if (hold_valid_ff && !push_ready) begin
         hold_valid_in = 1'b1;
      end else begin
         hold_valid_in = accept && (dec_op != OP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff.op            <= dec_op;
         hold_item_ff.entry_index   <= req_ch.entry_index;
         hold_item_ff.virtual_base  <= req_ch.entry_virtual_base;
         hold_item_ff.raw_size      <= req_ch.entry_raw_size;
         hold_item_ff.virtual_size  <= req_ch.entry_virtual_size;
         hold_item_ff.file_base     <= req_ch.entry_file_base;
         hold_item_ff.query_address <= req_ch.query_address;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

endmodule

[src/srat_queue.sv]
`timescale 1ns / 1ps
// Short FIFO decoupling the front stage from the table engine.
// Depends on srat_pkg.
module srat_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  srat_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output srat_pkg::item_type pop_item
);
   import srat_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               do_push, do_pop;

   assign push_ready = (level_ff != LEVEL_W'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (!do_push && do_pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/srat_back.sv]
`timescale 1ns / 1ps
// Table engine: holds the section table and scans it one entry per cycle.
// Depends on srat_pkg and srat_rsp_if.
module srat_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [srat_pkg::CNT_W-1:0]    csr_wdata,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  srat_pkg::item_type            pop_item,
   srat_rsp_if.source                    rsp_ch
);
   import srat_pkg::*;

   entry_type          entry_mem [MAX_SECTIONS];
   entry_type          rd_entry_ff;
   entry_type          load_entry;
   logic [SEC_AW-1:0]  rd_addr;
   logic               tbl_we;

   logic [CNT_W-1:0]   search_count_ff;
   logic [NUM_W-1:0]   active_n;

   back_state_type     state_ff, state_in;
   op_type             op_ff;
   logic [ADDR_W-1:0]  query_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [SEC_AW-1:0]  cur_ff;
   result_type         res_ff;
   logic               out_valid_ff, out_valid_in;
   result_type         out_data_ff;

   logic               take, is_query, last, out_load;
   logic [ADDR_W-1:0]  big_size;
   logic               va_ge, raw_hit, image_hit, file_hit;

   assign active_n = (32'(search_count_ff) > MAX_SECTIONS) ? NUM_W'(MAX_SECTIONS)
                                                            : NUM_W'(search_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         search_count_ff <= '0;
      end else if (csr_we) begin
         search_count_ff <= csr_wdata;
      end
   end

   // entry ends and offset delta are worked out once, at load
   assign big_size = (pop_item.raw_size > pop_item.virtual_size) ? pop_item.raw_size
                                                                 : pop_item.virtual_size;
   always_comb begin
      load_entry.virtual_base = pop_item.virtual_base;
      load_entry.file_base    = pop_item.file_base;
      load_entry.delta        = pop_item.file_base - pop_item.virtual_base;
      load_entry.raw_end      = {1'b0, pop_item.virtual_base} + {1'b0, pop_item.raw_size};
      load_entry.image_end    = {1'b0, pop_item.virtual_base} + {1'b0, big_size};
      load_entry.file_end     = {1'b0, pop_item.file_base} + {1'b0, pop_item.raw_size};
   end

   assign take     = pop_valid && pop_ready;
   assign is_query = (pop_item.op != OP_LOAD);
   assign last     = (NUM_W'(cur_ff) == num_ff - NUM_W'(1));
   assign out_load = (state_ff == BK_RESULT) && (!out_valid_ff || rsp_ch.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (take && is_query) begin
               state_in = (active_n == '0) ? BK_RESULT : BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (last) begin
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_ready = 1'b0;
      tbl_we    = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            tbl_we    = pop_valid && !is_query &&
                        (32'(pop_item.entry_index) < MAX_SECTIONS);
         end
         BK_SCAN: begin
            rd_addr = cur_ff + SEC_AW'(1);
         end
         BK_RESULT: begin
            pop_ready = 1'b0;
         end
         default: pop_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         entry_mem[SEC_AW'(pop_item.entry_index)] <= load_entry;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   assign va_ge     = (query_ff >= rd_entry_ff.virtual_base);
   assign raw_hit   = va_ge && ({1'b0, query_ff} < rd_entry_ff.raw_end);
   assign image_hit = va_ge && ({1'b0, query_ff} < rd_entry_ff.image_end);
   assign file_hit  = (query_ff >= rd_entry_ff.file_base) &&
                      ({1'b0, query_ff} < rd_entry_ff.file_end);

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && take && is_query) begin
         op_ff    <= pop_item.op;
         query_ff <= pop_item.query_address;
         num_ff   <= active_n;
         cur_ff   <= '0;
         res_ff   <= '0;
      end else if (state_ff == BK_SCAN) begin
         cur_ff <= cur_ff + SEC_AW'(1);
         if (op_ff == OP_QVA) begin
            if (!res_ff.hit && raw_hit) begin
               res_ff.hit        <= 1'b1;
               res_ff.translated <= query_ff + rd_entry_ff.delta;
            end
            if (!res_ff.in_image && image_hit) begin
               res_ff.in_image      <= 1'b1;
               res_ff.image_section <= IDX_W'(cur_ff);
            end
         end else if (!res_ff.hit && file_hit) begin
            res_ff.hit         <= 1'b1;
            res_ff.translated  <= query_ff - rd_entry_ff.delta;
            res_ff.hit_section <= IDX_W'(cur_ff);
         end
      end
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= res_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.hit           = out_data_ff.hit;
   assign rsp_ch.translated    = out_data_ff.translated;
   assign rsp_ch.hit_section   = out_data_ff.hit_section;
   assign rsp_ch.in_image      = out_data_ff.in_image;
   assign rsp_ch.image_section = out_data_ff.image_section;

endmodule

[src/section_range_address_translator.sv]
`timescale 1ns / 1ps
// Top level of the section range address translator.
// Depends on srat_pkg, srat_if, srat_front, srat_queue and srat_back.
//
// Usage:
//  - req_ch carries one beat per item: op 0 loads a section entry into slot
//    entry_index, op 1 translates a virtual address to a file offset, op 2
//    translates a file offset to a virtual address. Op 3 is dropped.
//  - rsp_ch returns one beat per query; loads return nothing.
//  - csr_we / csr_wdata set the search count, the number of entries searched
//    (saturated to the table size). Write it only while the block is idle.
//  - A query holds the table engine, which pops nothing else meanwhile, from
//    its pop through a scan of one searched entry per cycle to the result
//    hand-off; the single table read port sets this. Loads write on their pop.
//  - A request beat is registered in the front register and then in a queue
//    slot before the table engine pops it.
//  - A stalled rsp_ch holds the result in the output register; the engine
//    finishes one more query and waits, then the queue and front register
//    fill up and req_ch.ready drops.
//  - Reset clears the search count to 0 and empties the pipeline; table
//    contents are not cleared and must be loaded before they are searched.
module section_range_address_translator (
   input  logic                          clock,
   input  logic                          reset,
   srat_req_if.sink                      req_ch,
   srat_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [srat_pkg::CNT_W-1:0]    csr_wdata
);
   import srat_pkg::*;

   // front -> queue
   item_type push_item;
   logic     push_valid, push_ready;
   // queue -> engine
   item_type pop_item;
   logic     pop_valid, pop_ready;

   srat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   srat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   srat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_ch     (rsp_ch)
   );

endmodule

[tb/section_range_address_translator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for section_range_address_translator: a directed table, then
// random phases under several section counts and idle patterns. Needs srat_pkg, srat_if, RTL.
module section_range_address_translator_test;
   import srat_pkg::*;

   localparam int CYCLE_LIMIT  = 400000; // far above the slowest legal run
   localparam int DRAIN_CYCLES = 40;     // outlasts the request-to-response path at a full table
   localparam int RANDOM_ITEMS = 1550;
   localparam int NUM_PHASES   = 9;
   localparam int MAX_GAP      = 20;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CNT_W-1:0] csr_wdata;

   srat_req_if req_bus();
   srat_rsp_if rsp_bus();

   section_range_address_translator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Our own image of the section table and the count register.
   logic [ADDR_W-1:0] sec_vbase [MAX_SECTIONS];
   logic [ADDR_W-1:0] sec_rsize [MAX_SECTIONS];
   logic [ADDR_W-1:0] sec_vsize [MAX_SECTIONS];
   logic [ADDR_W-1:0] sec_fbase [MAX_SECTIONS];
   int                sections_searched;

   // Expected response beats, oldest first.
   result_type pending_results [$];

   int error_count;
   int cycle_count;
   int send_idle_pct;
   int rsp_stall_pct;

   // One row of the directed table: either a count write or a request beat.
   // Rows marked typed carry a hand-written response instead of the predicted one.
   typedef struct {
      bit               set_count;
      logic [CNT_W-1:0] count_value;
      item_type         beat;
      bit               typed;
      result_type       want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   // ------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending",
                  cycle_count, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Half-open range test with a 33-bit end, so base + size never wraps.
   function automatic logic in_span(input logic [ADDR_W-1:0] q, base, size);
      logic [ADDR_W:0] span_end;
      span_end = {1'b0, base} + {1'b0, size};
      return (q >= base) && ({1'b0, q} < span_end);
   endfunction

   // Applies one accepted beat to the table image; returns 1 when a response is due.
   function automatic bit translate_beat(input item_type it, output result_type res);
      logic [ADDR_W-1:0] big;
      logic [ADDR_W-1:0] q;
      res = '0;
      q   = it.query_address;
      if (it.op == OP_LOAD) begin
         // 4-bit slot index always lands inside the 16-entry table
         sec_vbase[it.entry_index] = it.virtual_base;
         sec_rsize[it.entry_index] = it.raw_size;
         sec_vsize[it.entry_index] = it.virtual_size;
         sec_fbase[it.entry_index] = it.file_base;
         return 1'b0;
      end
      if (it.op == OP_NONE)
         return 1'b0;
      for (int i = 0; i < sections_searched; i++) begin
         if (it.op == OP_QVA) begin
            big = (sec_rsize[i] > sec_vsize[i]) ? sec_rsize[i] : sec_vsize[i];
            if (!res.hit && in_span(q, sec_vbase[i], sec_rsize[i])) begin
               res.hit        = 1'b1;
               res.translated = q - sec_vbase[i] + sec_fbase[i];
            end
            if (!res.in_image && in_span(q, sec_vbase[i], big)) begin
               res.in_image      = 1'b1;
               res.image_section = IDX_W'(i);
            end
         end else if (!res.hit && in_span(q, sec_fbase[i], sec_rsize[i])) begin
            res.hit         = 1'b1;
            res.translated  = q - sec_fbase[i] + sec_vbase[i];
            res.hit_section = IDX_W'(i);
         end
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got, want);
      $display("[cycle %0d] %s: got %h, want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing pending", rsp_bus.translated, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.hit !== want.hit)
               report_mismatch("hit", ADDR_W'(rsp_bus.hit), ADDR_W'(want.hit));
            if (rsp_bus.translated !== want.translated)
               report_mismatch("translated", rsp_bus.translated, want.translated);
            if (rsp_bus.hit_section !== want.hit_section)
               report_mismatch("hit_section", ADDR_W'(rsp_bus.hit_section),
                               ADDR_W'(want.hit_section));
            if (rsp_bus.in_image !== want.in_image)
               report_mismatch("in_image", ADDR_W'(rsp_bus.in_image), ADDR_W'(want.in_image));
            if (rsp_bus.image_section !== want.image_section)
               report_mismatch("image_section", ADDR_W'(rsp_bus.image_section),
                               ADDR_W'(want.image_section));
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Idle for the requested gap, present the beat on a falling edge, hold it until taken.
   // Back-to-back beats keep valid high: only one assignment per falling edge.
   task automatic send_beat(input item_type it, input int gap, input bit typed,
                            input result_type want);
      result_type predicted;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid              <= 1'b1;
      req_bus.op                 <= it.op;
      req_bus.entry_index        <= it.entry_index;
      req_bus.entry_virtual_base <= it.virtual_base;
      req_bus.entry_raw_size     <= it.raw_size;
      req_bus.entry_virtual_size <= it.virtual_size;
      req_bus.entry_file_base    <= it.file_base;
      req_bus.query_address      <= it.query_address;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (translate_beat(it, predicted))
         pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_results;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Count writes only with the block idle. Loads leave nothing pending, so
   // let the pipeline run dry first.
   task automatic set_search_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sections_searched = (value > MAX_SECTIONS) ? MAX_SECTIONS : int'(value);
   endtask

   function automatic int next_gap;
      int g;
      g = 0;
      while (g < MAX_GAP && $urandom_range(99) < send_idle_pct) g++;
      return g;
   endfunction

   // ------------------------------------------------------------------
   // Directed table builders
   // ------------------------------------------------------------------
   task automatic row_load(input logic [IDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] vb, rs, vs, fb);
      stim_row_type r;
      r.set_count         = 1'b0;
      r.count_value       = '0;
      r.beat              = '0;
      r.beat.op           = OP_LOAD;
      r.beat.entry_index  = idx;
      r.beat.virtual_base = vb;
      r.beat.raw_size     = rs;
      r.beat.virtual_size = vs;
      r.beat.file_base    = fb;
      r.typed             = 1'b0;
      r.want              = '0;
      directed_rows.push_back(r);
   endtask

   task automatic row_query(input op_type op, input logic [ADDR_W-1:0] q,
                            input bit typed, input result_type want);
      stim_row_type r;
      r.set_count          = 1'b0;
      r.count_value        = '0;
      r.beat               = '0;
      r.beat.op            = op;
      r.beat.query_address = q;
      r.typed              = typed;
      r.want               = want;
      directed_rows.push_back(r);
   endtask

   task automatic row_count(input logic [CNT_W-1:0] value);
      stim_row_type r;
      r.set_count   = 1'b1;
      r.count_value = value;
      r.beat        = '0;
      r.typed       = 1'b0;
      r.want        = '0;
      directed_rows.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand_word;
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(32'h3FFF);
         3:       return 32'h0001_0000 + $urandom_range(32'h8000);
         4:       return 32'hFFFF_0000 | $urandom_range(32'hFFFF);
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sizes so that ranges end inside the address space and overlap.
   function automatic logic [ADDR_W-1:0] rand_size;
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3:       return 32'd1;
         default: return $urandom_range(32'h3000);
      endcase
   endfunction

   // Bases clustered around a region so neighboring sections overlap often.
   function automatic logic [ADDR_W-1:0] rand_base(input logic [ADDR_W-1:0] region);
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return 32'hFFFF_F000 | $urandom_range(32'hFFF);
         default: return region + $urandom_range(32'h8000);
      endcase
   endfunction

   // Mostly aims at a searched section: inside, first byte, last byte, one past, one before.
   function automatic logic [ADDR_W-1:0] rand_query_address(input op_type op);
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
      int                e;
      if (sections_searched == 0 || $urandom_range(7) == 0)
         return rand_word();
      e    = $urandom_range(sections_searched - 1);
      base = (op == OP_QVA) ? sec_vbase[e] : sec_fbase[e];
      size = sec_rsize[e];
      if (op == OP_QVA && $urandom_range(1) && sec_vsize[e] > size)
         size = sec_vsize[e];
      case ($urandom_range(4))
         0:       return base;
         1:       return base + size - 1;
         2:       return base + size;
         3:       return base - 1;
         default: return (size == 0) ? base : base + ($urandom % size);
      endcase
   endfunction

   function automatic item_type rand_load(input logic [IDX_W-1:0] idx);
      item_type it;
      it.op            = OP_LOAD;
      it.entry_index   = idx;
      it.virtual_base  = rand_base(32'h0001_0000);
      it.raw_size      = rand_size();
      it.virtual_size  = rand_size();
      it.file_base     = rand_base(32'h0000_0400);
      it.query_address = $urandom;
      return it;
   endfunction

   // About 12% loads, 3% unused op, the rest split between the two queries.
   // Fields a query ignores still carry random bits.
   function automatic item_type rand_item;
      item_type it;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 12)
         return rand_load(IDX_W'($urandom));
      it.entry_index   = IDX_W'($urandom);
      it.virtual_base  = $urandom;
      it.raw_size      = $urandom;
      it.virtual_size  = $urandom;
      it.file_base     = $urandom;
      it.query_address = $urandom;
      if (pick < 15) begin
         it.op = OP_NONE;
      end else begin
         it.op            = (pick < 57) ? OP_QVA : OP_QFO;
         it.query_address = rand_query_address(it.op);
      end
      return it;
   endfunction

   function automatic logic [CNT_W-1:0] phase_count(input int p);
      case (p)
         0:       return 5'd16;
         1:       return 5'd0;
         2:       return 5'd31;   // saturates to a full table
         3:       return 5'd1;
         4:       return 5'd7;
         5:       return 5'd16;
         6:       return 5'd20;
         7:       return CNT_W'($urandom_range(15, 2));
         default: return 5'd16;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int per_phase;
      int mode;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_LOAD;
      req_bus.entry_index        = '0;
      req_bus.entry_virtual_base = '0;
      req_bus.entry_raw_size     = '0;
      req_bus.entry_virtual_size = '0;
      req_bus.entry_file_base    = '0;
      req_bus.query_address      = '0;
      rsp_bus.ready      = 1'b0;
      sections_searched  = 0;
      error_count        = 0;
      cycle_count        = 0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Count is 0 after reset: queries come back all zero.
      row_query(OP_QVA, 32'h0000_0000, 1'b1, '0);
      row_query(OP_QFO, 32'hFFFF_FFFF, 1'b1, '0);
      row_query(OP_NONE, 32'h0000_1000, 1'b0, '0);
      // Slot 1 ends past 2^32, slot 2 has an empty raw range but a full
      // virtual extent, slot 3 overlaps slot 0.
      row_load(4'd0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0200, 32'h0000_0400);
      row_load(4'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      row_load(4'd2, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      row_load(4'd3, 32'h0000_1080, 32'h0000_0080, 32'h0000_0010, 32'h0000_2000);
      row_count(5'd4);
      row_query(OP_QVA, 32'h0000_1000, 1'b1, result_type'{1'b1, 32'h400, 4'd0, 1'b1, 4'd0});
      row_query(OP_QVA, 32'h0000_10FF, 1'b0, '0);
      row_query(OP_QVA, 32'h0000_1100, 1'b0, '0);  // past raw end, inside virtual
      row_query(OP_QVA, 32'h0000_1080, 1'b0, '0);  // overlap: first entry wins
      row_query(OP_QVA, 32'hFFFF_FFFF, 1'b1, result_type'{1'b1, 32'hFF, 4'd0, 1'b1, 4'd1});
      row_query(OP_QVA, 32'h0000_0000, 1'b1, result_type'{1'b0, 32'h0, 4'd0, 1'b1, 4'd2});
      row_query(OP_QFO, 32'h0000_0000, 1'b1,
                result_type'{1'b1, 32'hFFFF_FF00, 4'd1, 1'b0, 4'd0});
      row_query(OP_QFO, 32'hFFFF_FFFF, 1'b0, '0);
      row_query(OP_QFO, 32'h0000_2040, 1'b0, '0);
      row_query(OP_NONE, 32'h0000_1000, 1'b0, '0);
      row_count(5'd1);
      row_query(OP_QVA, 32'h0000_1100, 1'b0, '0);
      row_query(OP_QVA, 32'hFFFF_FFFF, 1'b1, '0);
      row_query(OP_QFO, 32'h0000_0000, 1'b0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_count)
            set_search_count(directed_rows[i].count_value);
         else
            send_beat(directed_rows[i].beat, 0, directed_rows[i].typed,
                      directed_rows[i].want);
      end

      // Fill every slot before any count above four lets the search reach it.
      for (int s = 0; s < MAX_SECTIONS; s++)
         send_beat(rand_load(IDX_W'(s)), next_gap(), 1'b0, '0);

      // Random phases: count setting per phase, idle pattern rotating
      // through none / sender idle / receiver stall / both.
      per_phase = RANDOM_ITEMS / NUM_PHASES;
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_search_count(phase_count(p));
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 70 : (mode == 3) ? 27 : 0;
         rsp_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 27 : 0;
         for (int k = 0; k < per_phase; k++) begin
            // in phases 1, 4 and 7, hold off mid-phase until everything in flight has come back
            if (p % 3 == 1 && k == per_phase / 2) begin
               @(negedge clock);
               req_bus.valid <= 1'b0;
               wait_for_results();
            end
            send_beat(rand_item(), next_gap(), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
